// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl, empty for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while reset is low
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/mctp_pkg.sv -----
// ---------------------------------------------------------------------------
// mctp_pkg
// types and constants of the motor command text parser
// ---------------------------------------------------------------------------
package mctp_pkg;

    // input word: one message byte or the end marker
    typedef struct packed {
        logic [7:0] char_code;
        logic       is_end;
    } t_in_word;

    // output word: one parsed command
    typedef struct packed {
        logic               status;
        logic               command_kind;
        logic signed [31:0] speed;
        logic               direction;
    } t_out_word;

    // token numbers
    localparam logic [1:0] TOK_CMD   = 2'd0;
    localparam logic [1:0] TOK_SPEED = 2'd1;
    localparam logic [1:0] TOK_DIR   = 2'd2;
    localparam logic [1:0] TOK_DONE  = 2'd3;

    // message kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_FWD  = 2'd1;
    localparam logic [1:0] KIND_STOP = 2'd2;
    localparam logic [1:0] KIND_BWD  = 2'd3;

    // speed token phases
    localparam logic [2:0] PH_WS      = 3'd0;
    localparam logic [2:0] PH_PLUS    = 3'd1;
    localparam logic [2:0] PH_MINUS   = 3'd2;
    localparam logic [2:0] PH_POS_DIG = 3'd3;
    localparam logic [2:0] PH_NEG_DIG = 3'd4;
    localparam logic [2:0] PH_BAD     = 3'd5;

    // keyword slots in the match flags
    localparam int KW_MOVE = 0;
    localparam int KW_STOP = 1;
    localparam int KW_FWD  = 2;
    localparam int KW_BWD  = 3;

    // keyword text, indexed [keyword][position]
    localparam logic [3:0][7:0][7:0] KW_TEXT = '{
        '{8'h44, 8'h52, 8'h41, 8'h57, 8'h4B, 8'h43, 8'h41, 8'h42}, // BACKWARD
        '{8'h00, 8'h44, 8'h52, 8'h41, 8'h57, 8'h52, 8'h4F, 8'h46}, // FORWARD (msb first)
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h50, 8'h4F, 8'h54, 8'h53}, // STOP
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h45, 8'h56, 8'h4F, 8'h4D}  // MOVE
    };

    // keyword lengths
    localparam logic [3:0][3:0] KW_LEN = '{4'd8, 4'd7, 4'd4, 4'd4};

    localparam logic [3:0] FLAGS_ALL = 4'hF;
    localparam logic [3:0] POS_MAX   = 4'hF;

    // special characters
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

endpackage

// ----- rtl/core/motor_command_text_parser.sv -----
// ---------------------------------------------------------------------------
// motor_command_text_parser
// parses a comma-separated move/stop command, one byte per word
// ---------------------------------------------------------------------------
// Takes one byte per cycle while no closing word is held back, and gives one
// command word when a message closes (a NUL byte or a word with is_end set).
// An accepted word sits in the input register while the parse logic works on
// it; the parser state and the output register then update from it, so a
// command word passes through the input register and then the output
// register. A closing word waits in the input register only while the
// previous command word is still held and not taken. The longest path of the
// state update is the speed multiply-by-ten shift-add with its saturation
// compare. Commands are STOP (any tail) or MOVE,<speed>,FORWARD|BACKWARD; a
// rejected message gives status 1 with all other fields zero. Speeds saturate
// at SPEED_WIDTH bits and the low 32 bits of the saturated value are given.
module motor_command_text_parser #(
    parameter int SPEED_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  mctp_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output mctp_pkg::t_out_word  o_out_word
);

    localparam int AW = SPEED_WIDTH + 4;
    localparam int EW = SPEED_WIDTH + 32;

    // input register
    logic                r_in_valid;
    mctp_pkg::t_in_word  r_in_word;

    // parser state
    logic [1:0]             r_tok,    n_tok;
    logic                   r_in_tok, n_in_tok;
    logic [3:0]             r_pos,    n_pos;
    logic [3:0]             r_flags,  n_flags;
    logic [1:0]             r_kind,   n_kind;
    logic [SPEED_WIDTH-1:0] r_acc,    n_acc;
    logic [2:0]             r_phase,  n_phase;
    logic                   r_failed, n_failed;

    // output register
    logic                r_out_valid;
    mctp_pkg::t_out_word r_out_word, n_out_word;

    // combinational helpers
    logic                   w_close;
    logic                   w_comma;
    logic                   w_advance;
    logic [1:0]             w_ct_tok;
    logic [1:0]             w_ct_kind;
    logic                   w_ct_failed;
    logic                   w_start;
    logic [3:0]             w_pos;
    logic [3:0]             w_flags;
    logic [2:0]             w_phase;
    logic [SPEED_WIDTH-1:0] w_acc;
    logic                   w_space;
    logic                   w_digit;
    logic                   w_neg;
    logic [AW-1:0]          w_lim;
    logic [AW-1:0]          w_prod;
    logic                   w_ok;
    logic [EW-1:0]          w_acc_ext;
    logic [31:0]            w_acc32;

    // classify the held byte
    assign w_close = r_in_word.is_end || (r_in_word.char_code == mctp_pkg::CHAR_NUL);
    assign w_comma = (r_in_word.char_code == mctp_pkg::CHAR_COMMA);

    // handshake: a non-closing word always advances, a closing one needs the output slot
    assign w_advance  = r_in_valid && (!w_close || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    // token close decision from the current state
    always_comb begin
        w_ct_tok    = r_tok;
        w_ct_kind   = r_kind;
        w_ct_failed = r_failed;
        if (!r_failed && r_tok != mctp_pkg::TOK_DONE) begin
            unique case (r_tok)
                mctp_pkg::TOK_CMD: begin
                    if (r_flags[mctp_pkg::KW_MOVE] && r_pos == mctp_pkg::KW_LEN[mctp_pkg::KW_MOVE]) begin
                        w_ct_kind = mctp_pkg::KIND_FWD;
                        w_ct_tok  = mctp_pkg::TOK_SPEED;
                    end else if (r_flags[mctp_pkg::KW_STOP]
                                 && r_pos == mctp_pkg::KW_LEN[mctp_pkg::KW_STOP]) begin
                        w_ct_kind = mctp_pkg::KIND_STOP;
                        w_ct_tok  = mctp_pkg::TOK_DONE;
                    end else begin
                        w_ct_failed = 1'b1;
                    end
                end
                mctp_pkg::TOK_SPEED: begin
                    if (r_phase == mctp_pkg::PH_POS_DIG || r_phase == mctp_pkg::PH_NEG_DIG) begin
                        w_ct_tok = mctp_pkg::TOK_DIR;
                    end else begin
                        w_ct_failed = 1'b1;
                    end
                end
                default: begin
                    if (r_flags[mctp_pkg::KW_FWD] && r_pos == mctp_pkg::KW_LEN[mctp_pkg::KW_FWD]) begin
                        w_ct_tok = mctp_pkg::TOK_DONE;
                    end else if (r_flags[mctp_pkg::KW_BWD]
                                 && r_pos == mctp_pkg::KW_LEN[mctp_pkg::KW_BWD]) begin
                        w_ct_kind = mctp_pkg::KIND_BWD;
                        w_ct_tok  = mctp_pkg::TOK_DONE;
                    end else begin
                        w_ct_failed = 1'b1;
                    end
                end
            endcase
        end
    end

    // token-local values after a possible token start
    assign w_start = !r_in_tok;
    assign w_pos   = w_start ? 4'd0 : r_pos;
    assign w_flags = w_start ? mctp_pkg::FLAGS_ALL : r_flags;
    assign w_phase = (w_start && r_tok == mctp_pkg::TOK_SPEED) ? mctp_pkg::PH_WS : r_phase;
    assign w_acc   = (w_start && r_tok == mctp_pkg::TOK_SPEED) ? '0 : r_acc;

    // speed digit arithmetic: acc * 10 + d against the signed limit
    assign w_space = (r_in_word.char_code == mctp_pkg::CHAR_SPACE)
                  || (r_in_word.char_code >= mctp_pkg::CHAR_TAB
                      && r_in_word.char_code <= mctp_pkg::CHAR_CR);
    assign w_digit = (r_in_word.char_code >= mctp_pkg::CHAR_ZERO)
                  && (r_in_word.char_code <= mctp_pkg::CHAR_NINE);
    assign w_neg   = (w_phase == mctp_pkg::PH_MINUS) || (w_phase == mctp_pkg::PH_NEG_DIG);
    assign w_lim   = w_neg ? (AW'(1) << (SPEED_WIDTH - 1))
                           : ((AW'(1) << (SPEED_WIDTH - 1)) - AW'(1));
    assign w_prod  = AW'({w_acc, 3'b000}) + AW'({w_acc, 1'b0})
                   + AW'(r_in_word.char_code - mctp_pkg::CHAR_ZERO);

    // result speed from the accumulator, low 32 bits
    assign w_acc_ext = {32'd0, r_acc};
    assign w_acc32   = w_acc_ext[31:0];

    // next state and result word
    always_comb begin
        n_tok      = r_tok;
        n_in_tok   = r_in_tok;
        n_pos      = r_pos;
        n_flags    = r_flags;
        n_kind     = r_kind;
        n_acc      = r_acc;
        n_phase    = r_phase;
        n_failed   = r_failed;
        n_out_word = r_out_word;
        w_ok       = 1'b0;

        if (w_close) begin
            // apply a pending token close, judge, then return to reset
            if (r_in_tok) begin
                w_ok = !w_ct_failed
                    && (w_ct_kind == mctp_pkg::KIND_STOP
                        || ((w_ct_kind == mctp_pkg::KIND_FWD || w_ct_kind == mctp_pkg::KIND_BWD)
                            && w_ct_tok == mctp_pkg::TOK_DONE));
            end else begin
                w_ok = !r_failed
                    && (r_kind == mctp_pkg::KIND_STOP
                        || ((r_kind == mctp_pkg::KIND_FWD || r_kind == mctp_pkg::KIND_BWD)
                            && r_tok == mctp_pkg::TOK_DONE));
            end
            n_out_word.status       = !w_ok;
            n_out_word.command_kind = 1'b0;
            n_out_word.speed        = '0;
            n_out_word.direction    = 1'b0;
            if (w_ok && ((r_in_tok ? w_ct_kind : r_kind) == mctp_pkg::KIND_STOP)) begin
                n_out_word.command_kind = 1'b1;
            end else if (w_ok) begin
                n_out_word.speed = (r_phase == mctp_pkg::PH_NEG_DIG)
                                 ? $signed(32'd0 - w_acc32) : $signed(w_acc32);
                n_out_word.direction = (r_kind == mctp_pkg::KIND_BWD)
                                    || (r_in_tok && w_ct_kind == mctp_pkg::KIND_BWD);
            end
            n_tok    = mctp_pkg::TOK_CMD;
            n_in_tok = 1'b0;
            n_pos    = 4'd0;
            n_flags  = mctp_pkg::FLAGS_ALL;
            n_kind   = mctp_pkg::KIND_NONE;
            n_acc    = '0;
            n_phase  = mctp_pkg::PH_WS;
            n_failed = 1'b0;
        end else if (w_comma) begin
            // separator: close the open token, runs of commas do nothing more
            if (r_in_tok) begin
                n_tok    = w_ct_tok;
                n_kind   = w_ct_kind;
                n_failed = w_ct_failed;
                n_in_tok = 1'b0;
            end
        end else if (!r_failed && r_tok != mctp_pkg::TOK_DONE) begin
            n_in_tok = 1'b1;
            n_pos    = w_pos;
            n_flags  = w_flags;
            n_phase  = w_phase;
            n_acc    = w_acc;
            if (r_tok == mctp_pkg::TOK_SPEED) begin
                // speed token character
                if (w_phase != mctp_pkg::PH_BAD) begin
                    if (w_digit) begin
                        if (w_phase == mctp_pkg::PH_WS || w_phase == mctp_pkg::PH_PLUS
                            || w_phase == mctp_pkg::PH_MINUS) begin
                            n_phase = w_neg ? mctp_pkg::PH_NEG_DIG : mctp_pkg::PH_POS_DIG;
                        end
                        n_acc = (w_prod > w_lim) ? w_lim[SPEED_WIDTH-1:0]
                                                 : w_prod[SPEED_WIDTH-1:0];
                    end else if (w_phase == mctp_pkg::PH_WS && w_space) begin
                        n_phase = mctp_pkg::PH_WS;
                    end else if (w_phase == mctp_pkg::PH_WS
                                 && r_in_word.char_code == mctp_pkg::CHAR_PLUS) begin
                        n_phase = mctp_pkg::PH_PLUS;
                    end else if (w_phase == mctp_pkg::PH_WS
                                 && r_in_word.char_code == mctp_pkg::CHAR_MINUS) begin
                        n_phase = mctp_pkg::PH_MINUS;
                    end else begin
                        n_phase = mctp_pkg::PH_BAD;
                    end
                end
            end else begin
                // keyword character: drop every keyword that no longer matches
                for (int k = 0; k < 4; k++) begin
                    if (w_pos >= mctp_pkg::KW_LEN[k]
                        || mctp_pkg::KW_TEXT[k][w_pos[2:0]] != r_in_word.char_code) begin
                        n_flags[k] = 1'b0;
                    end
                end
                if (w_pos != mctp_pkg::POS_MAX) begin
                    n_pos = w_pos + 4'd1;
                end
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok    <= mctp_pkg::TOK_CMD;
            r_in_tok <= 1'b0;
            r_pos    <= 4'd0;
            r_flags  <= mctp_pkg::FLAGS_ALL;
            r_kind   <= mctp_pkg::KIND_NONE;
            r_acc    <= '0;
            r_phase  <= mctp_pkg::PH_WS;
            r_failed <= 1'b0;
        end else if (w_advance) begin
            r_tok    <= n_tok;
            r_in_tok <= n_in_tok;
            r_pos    <= n_pos;
            r_flags  <= n_flags;
            r_kind   <= n_kind;
            r_acc    <= n_acc;
            r_phase  <= n_phase;
            r_failed <= n_failed;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_close) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance && w_close) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // checks
`include "assert_macros.svh"

    `ASSERT_SAME(a_reject_zero, i_clk, i_rst_n, o_out_valid && o_out_word.status, !o_out_word.command_kind && o_out_word.speed == 32'sd0 && !o_out_word.direction)
    `ASSERT_SAME(a_stop_zero, i_clk, i_rst_n, o_out_valid && o_out_word.command_kind, !o_out_word.status && o_out_word.speed == 32'sd0 && !o_out_word.direction)
    `ASSERT_SAME(a_hold_input, i_clk, i_rst_n, r_in_valid && !w_advance, !o_in_ready)
    `ASSERT_NEXT(a_close_reset, i_clk, i_rst_n, w_advance && w_close, r_tok == mctp_pkg::TOK_CMD && !r_in_tok && !r_failed && r_kind == mctp_pkg::KIND_NONE)

endmodule

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// checks the motor command text parser against a byte-level parse predictor
// ---------------------------------------------------------------------------
// Sends comma-separated command messages one byte per word: a few fixed
// messages first, then random ones. Most random messages are well-formed
// MOVE or STOP commands with random speeds, separators and keyword damage.
// The rest are broken or plain noise. A scoreboard parses each accepted
// word on its own and checks every command word, field by field, in order.
// Both sides idle at random. A calm window runs with no idling, and one
// long receiver hold-off fills the block so that it stalls its input.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET    = 650;
    localparam int MIN_MESSAGES   = 48;
    localparam int IDLE_PCT       = 11;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 20;

    // command word field codes
    localparam logic ST_OK     = 1'b0;
    localparam logic ST_REJECT = 1'b1;
    localparam logic CK_MOVE   = 1'b0;
    localparam logic CK_STOP   = 1'b1;
    localparam logic DIR_FWD   = 1'b0;
    localparam logic DIR_BWD   = 1'b1;

    // saturation limits of the speed magnitude
    localparam logic [63:0] SPEED_POS_MAX = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] SPEED_NEG_MAX = 64'h0000_0000_8000_0000;

    // parse predictor and queue of commands still due
    class command_checker;
        logic [1:0]          tok;
        bit                  in_tok;
        logic [3:0]          pos;
        logic [3:0]          kw_ok;
        logic [1:0]          kind;
        logic [63:0]         mag;
        logic [2:0]          ph;
        bit                  rejected;
        string               kw_word[4];
        mctp_pkg::t_out_word due[$];
        int                  errors;

        function new();
            kw_word[mctp_pkg::KW_MOVE] = "MOVE";
            kw_word[mctp_pkg::KW_STOP] = "STOP";
            kw_word[mctp_pkg::KW_FWD]  = "FORWARD";
            kw_word[mctp_pkg::KW_BWD]  = "BACKWARD";
            errors = 0;
            clear();
        endfunction

        function void clear();
            tok      = mctp_pkg::TOK_CMD;
            in_tok   = 1'b0;
            pos      = '0;
            kw_ok    = mctp_pkg::FLAGS_ALL;
            kind     = mctp_pkg::KIND_NONE;
            mag      = '0;
            ph       = mctp_pkg::PH_WS;
            rejected = 1'b0;
        endfunction

        function bit kw_hit(int k);
            return kw_ok[k] && (pos == kw_word[k].len());
        endfunction

        // token boundary: decide what the finished token means
        function void close_token();
            in_tok = 1'b0;
            if (rejected || tok == mctp_pkg::TOK_DONE)
                return;
            case (tok)
                mctp_pkg::TOK_CMD: begin
                    if (kw_hit(mctp_pkg::KW_MOVE)) begin
                        kind = mctp_pkg::KIND_FWD;
                        tok  = mctp_pkg::TOK_SPEED;
                    end else if (kw_hit(mctp_pkg::KW_STOP)) begin
                        kind = mctp_pkg::KIND_STOP;
                        tok  = mctp_pkg::TOK_DONE;
                    end else begin
                        rejected = 1'b1;
                    end
                end
                mctp_pkg::TOK_SPEED: begin
                    if (ph == mctp_pkg::PH_POS_DIG || ph == mctp_pkg::PH_NEG_DIG)
                        tok = mctp_pkg::TOK_DIR;
                    else
                        rejected = 1'b1;
                end
                default: begin
                    if (kw_hit(mctp_pkg::KW_FWD)) begin
                        tok = mctp_pkg::TOK_DONE;
                    end else if (kw_hit(mctp_pkg::KW_BWD)) begin
                        kind = mctp_pkg::KIND_BWD;
                        tok  = mctp_pkg::TOK_DONE;
                    end else begin
                        rejected = 1'b1;
                    end
                end
            endcase
        endfunction

        // keyword tokens: drop every keyword this byte rules out
        function void match_char(logic [7:0] c);
            for (int k = 0; k < 4; k++) begin
                if (pos >= kw_word[k].len() || kw_word[k][pos] != c)
                    kw_ok[k] = 1'b0;
            end
            if (pos != mctp_pkg::POS_MAX)
                pos++;
        endfunction

        // speed token: whitespace, sign, then saturating decimal digits
        function void speed_char(logic [7:0] c);
            bit          neg;
            bit          blank;
            logic [63:0] lim;
            logic [63:0] d;
            if (ph == mctp_pkg::PH_BAD)
                return;
            blank = (c == mctp_pkg::CHAR_SPACE)
                 || (c >= mctp_pkg::CHAR_TAB && c <= mctp_pkg::CHAR_CR);
            if (c >= mctp_pkg::CHAR_ZERO && c <= mctp_pkg::CHAR_NINE) begin
                neg = (ph == mctp_pkg::PH_MINUS || ph == mctp_pkg::PH_NEG_DIG);
                lim = neg ? SPEED_NEG_MAX : SPEED_POS_MAX;
                d   = 64'(c) - 64'(mctp_pkg::CHAR_ZERO);
                if (ph == mctp_pkg::PH_WS || ph == mctp_pkg::PH_PLUS
                    || ph == mctp_pkg::PH_MINUS)
                    ph = neg ? mctp_pkg::PH_NEG_DIG : mctp_pkg::PH_POS_DIG;
                if (mag > (lim - d) / 10)
                    mag = lim;
                else
                    mag = mag * 10 + d;
            end else if (ph != mctp_pkg::PH_WS) begin
                ph = mctp_pkg::PH_BAD;
            end else if (c == mctp_pkg::CHAR_PLUS) begin
                ph = mctp_pkg::PH_PLUS;
            end else if (c == mctp_pkg::CHAR_MINUS) begin
                ph = mctp_pkg::PH_MINUS;
            end else if (!blank) begin
                ph = mctp_pkg::PH_BAD;
            end
        endfunction

        // one accepted word; a closing word queues the command it gives
        function void note_byte(mctp_pkg::t_in_word w);
            mctp_pkg::t_out_word cmd;
            bit                  ok;
            logic [63:0]         v;
            if (w.is_end || w.char_code == mctp_pkg::CHAR_NUL) begin
                if (in_tok)
                    close_token();
                ok = !rejected && (kind == mctp_pkg::KIND_STOP ||
                     ((kind == mctp_pkg::KIND_FWD || kind == mctp_pkg::KIND_BWD)
                      && tok == mctp_pkg::TOK_DONE));
                cmd = '0;
                cmd.status = ok ? ST_OK : ST_REJECT;
                if (ok && kind == mctp_pkg::KIND_STOP) begin
                    cmd.command_kind = CK_STOP;
                end else if (ok) begin
                    v = (ph == mctp_pkg::PH_NEG_DIG) ? -mag : mag;
                    cmd.command_kind = CK_MOVE;
                    cmd.speed        = v[31:0];
                    cmd.direction    = (kind == mctp_pkg::KIND_BWD) ? DIR_BWD : DIR_FWD;
                end
                due.push_back(cmd);
                clear();
                return;
            end
            if (w.char_code == mctp_pkg::CHAR_COMMA) begin
                if (in_tok)
                    close_token();
                return;
            end
            if (rejected || tok == mctp_pkg::TOK_DONE)
                return;
            if (!in_tok) begin
                in_tok = 1'b1;
                pos    = '0;
                kw_ok  = mctp_pkg::FLAGS_ALL;
                if (tok == mctp_pkg::TOK_SPEED) begin
                    ph  = mctp_pkg::PH_WS;
                    mag = '0;
                end
            end
            if (tok == mctp_pkg::TOK_SPEED)
                speed_char(w.char_code);
            else
                match_char(w.char_code);
        endfunction

        function void field_check(string name, longint want, longint got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        // one accepted command word against the oldest one due
        function void check_command(mctp_pkg::t_out_word got);
            mctp_pkg::t_out_word want;
            if (due.size() == 0) begin
                errors++;
                $display("%0t: command word with none due, actual %0d %0d %0d %0d",
                         $time, got.status, got.command_kind, got.speed, got.direction);
                return;
            end
            want = due.pop_front();
            field_check("status", want.status, got.status);
            field_check("command_kind", want.command_kind, got.command_kind);
            field_check("speed", want.speed, got.speed);
            field_check("direction", want.direction, got.direction);
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    mctp_pkg::t_in_word  in_word;
    logic                out_valid;
    logic                out_ready;
    mctp_pkg::t_out_word out_word;

    command_checker sb;
    logic [7:0]     body[$];
    int             words_sent = 0;
    int             msgs_sent  = 0;
    int             quiet_cycles = 0;
    bit             calm    = 1'b1;
    bit             hold_req = 1'b0;

    motor_command_text_parser dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        out_ready = 1'b0;
        forever @(negedge clk) begin
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end else begin
                out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // command word monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_command(out_word);
    end

    // cycles with no word moving on either side
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // watchdog
    initial begin
        @(posedge clk);
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("FAIL");
        $finish;
    end

    // offer one word, with random idle cycles ahead of it; starts and ends at a falling edge
    task automatic send_word(mctp_pkg::t_in_word w);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            in_word  <= 9'($urandom);
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_byte(w);
        words_sent++;
        @(negedge clk);
    endtask

    // send the message body, then close it by end flag or NUL byte
    task automatic send_body(bit by_flag);
        mctp_pkg::t_in_word w;
        foreach (body[i]) begin
            w.char_code = body[i];
            w.is_end    = 1'b0;
            send_word(w);
        end
        w.char_code = by_flag ? 8'($urandom) : mctp_pkg::CHAR_NUL;
        w.is_end    = by_flag;
        send_word(w);
        msgs_sent++;
    endtask

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++)
            body.push_back(s[i]);
    endfunction

    task automatic send_str(string s, bit by_flag);
        body.delete();
        add_str(s);
        send_body(by_flag);
    endtask

    // mostly one comma, sometimes a run
    function automatic void add_sep();
        int n;
        n = ($urandom_range(99) < 80) ? 1 : $urandom_range(3, 2);
        repeat (n) body.push_back(mctp_pkg::CHAR_COMMA);
    endfunction

    function automatic void add_noise(int n);
        repeat (n) body.push_back(8'($urandom_range(255, 1)));
    endfunction

    // keyword, now and then damaged
    function automatic void add_keyword(string k);
        int p;
        p = $urandom_range(k.len() - 1);
        case ($urandom_range(19))
            0: add_str(k.substr(0, k.len() - 2));
            1: begin
                add_str(k);
                add_noise(1);
            end
            2: begin
                for (int i = 0; i < k.len(); i++)
                    body.push_back(i == p ? 8'($urandom_range(255, 1)) : k[i]);
            end
            3: begin
                add_str(k);
                add_noise($urandom_range(20, 12));
            end
            4: begin
                for (int i = 0; i < k.len(); i++)
                    body.push_back(k[i] | 8'h20);
            end
            default: add_str(k);
        endcase
    endfunction

    // speed token: whitespace, sign, digits, sometimes broken
    function automatic void add_speed();
        int    sel;
        int    flaw;
        string edge_num[5];
        edge_num = '{"2147483647", "2147483648", "2147483646", "21474836470", "2147483650"};
        flaw = ($urandom_range(99) < 12) ? $urandom_range(3) : -1;
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(2, 1))
                body.push_back($urandom_range(1)
                               ? mctp_pkg::CHAR_SPACE
                               : 8'($urandom_range(mctp_pkg::CHAR_CR, mctp_pkg::CHAR_TAB)));
        end
        sel = $urandom_range(99);
        if (sel >= 60 || flaw == 0 || flaw == 1)
            body.push_back(sel >= 80 ? mctp_pkg::CHAR_MINUS : mctp_pkg::CHAR_PLUS);
        if (flaw == 1)
            body.push_back(mctp_pkg::CHAR_SPACE);
        if (flaw != 0) begin
            sel = $urandom_range(99);
            if (sel < 10)
                add_str(edge_num[$urandom_range(4)]);
            else
                repeat (sel < 25 ? $urandom_range(12, 9) : $urandom_range(6, 1))
                    body.push_back(mctp_pkg::CHAR_ZERO + 8'($urandom_range(9)));
        end
        if (flaw == 2)
            add_noise(1);
        if (flaw == 3)
            body.push_back($urandom_range(1) ? mctp_pkg::CHAR_PLUS : mctp_pkg::CHAR_SPACE);
    endfunction

    // one random message: mostly well-formed, some broken, some noise
    task automatic random_message();
        int sel;
        body.delete();
        if ($urandom_range(3) == 0)
            add_sep();
        sel = $urandom_range(99);
        if (sel < 20) begin
            add_keyword("STOP");
            if ($urandom_range(1)) begin
                add_sep();
                add_noise($urandom_range(8));
            end
        end else if (sel < 90) begin
            add_keyword("MOVE");
            if (sel < 84 || $urandom_range(1)) begin
                add_sep();
                add_speed();
            end
            if (sel < 84 || $urandom_range(1)) begin
                add_sep();
                add_keyword($urandom_range(1) ? "FORWARD" : "BACKWARD");
            end
            if ($urandom_range(4) == 0) begin
                add_sep();
                add_noise($urandom_range(6));
            end
        end else begin
            add_noise($urandom_range(12));
        end
        if ($urandom_range(3) == 0)
            add_sep();
        send_body($urandom_range(1));
    endtask

    // main sequence
    initial begin
        sb       = new();
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_word  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // fixed messages
        send_str("", 1'b1);
        send_str(",,", 1'b0);
        body.delete();
        add_str("STOP,");
        body.push_back(8'hFF);
        send_body(1'b1);
        send_str(",MOVE,,-99999999999,BACKWARD,", 1'b0);
        send_str("MOVE,\t+2147483648,FORWARD,x", 1'b1);
        send_str("MOVE,- 5,FORWARD", 1'b0);
        send_str("MOVE,12", 1'b1);
        send_str("MOVE,3x,FORWARDS", 1'b0);

        // random messages, with a calm window and one long receiver hold-off
        while (words_sent < ITEM_TARGET || msgs_sent < MIN_MESSAGES) begin
            calm = (msgs_sent >= 20 && msgs_sent < 30);
            if (msgs_sent == 35)
                hold_req = 1'b1;
            random_message();
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // drain
        while (sb.due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/mctp_pkg.sv
rtl/core/motor_command_text_parser.sv
tb/testbench.sv
